// ===== rtl/wsalu_pkg.sv =====
package wsalu_pkg;

   localparam int DATA_W = 64;
   localparam int HALF_W = 32;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int RESULT_DEPTH_DEF = 4;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_REM = 3'd4;
   localparam logic [2:0] OP_AND = 3'd5;
   localparam logic [2:0] OP_OR  = 3'd6;
   localparam logic [2:0] OP_XOR = 3'd7;

   localparam logic [1:0] WC_8  = 2'd0;
   localparam logic [1:0] WC_16 = 2'd1;
   localparam logic [1:0] WC_32 = 2'd2;
   localparam logic [1:0] WC_64 = 2'd3;

   typedef struct packed {
      logic [2:0]        action;
      logic [1:0]        width_code;
      logic [DATA_W-1:0] left;
      logic [DATA_W-1:0] right;
      logic              neg_quo;
      logic              neg_rem;
      logic              div_zero;
   } item_type;

   localparam int ITEM_W = $bits(item_type);

   function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] wc);
      logic [DATA_W-1:0] m;
      case (wc)
         WC_8:    m = 64'h0000_0000_0000_00FF;
         WC_16:   m = 64'h0000_0000_0000_FFFF;
         WC_32:   m = 64'h0000_0000_FFFF_FFFF;
         WC_64:   m = 64'hFFFF_FFFF_FFFF_FFFF;
         default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [DATA_W-1:0] sign_bit(input logic [1:0] wc);
      logic [DATA_W-1:0] s;
      case (wc)
         WC_8:    s = 64'h0000_0000_0000_0080;
         WC_16:   s = 64'h0000_0000_0000_8000;
         WC_32:   s = 64'h0000_0000_8000_0000;
         WC_64:   s = 64'h8000_0000_0000_0000;
         default: s = 64'h8000_0000_0000_0000;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/wsalu_fifo.sv =====
module wsalu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           data_in,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           data_out,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH-1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign count    = cnt_ff;
   assign data_out = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = do_push ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= data_in;
      end
   end

endmodule

// ===== rtl/wsalu_front.sv =====
module wsalu_front #(
   parameter int QUEUE_DEPTH = wsalu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [2:0]                 action,
   input  logic [1:0]                 width_code,
   input  logic                       signed_op,
   input  logic [wsalu_pkg::DATA_W-1:0] left_operand,
   input  logic [wsalu_pkg::DATA_W-1:0] right_operand,
   input  logic                       take,
   output wsalu_pkg::item_type        head,
   output logic                       empty
);

   logic [wsalu_pkg::DATA_W-1:0] mask, sbit, a, b;
   logic                         neg_a, neg_b, is_divrem;
   wsalu_pkg::item_type          item;
   logic [wsalu_pkg::ITEM_W-1:0] head_bits;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] unused_count;

   always_comb begin
      mask      = wsalu_pkg::width_mask(width_code);
      sbit      = wsalu_pkg::sign_bit(width_code);
      a         = left_operand & mask;
      b         = right_operand & mask;
      is_divrem = (action == wsalu_pkg::OP_DIV) || (action == wsalu_pkg::OP_REM);
      neg_a     = signed_op && ((a & sbit) != '0);
      neg_b     = signed_op && ((b & sbit) != '0);
      item.action     = action;
      item.width_code = width_code;
      item.div_zero   = (b == '0);
      item.neg_quo    = neg_a ^ neg_b;
      item.neg_rem    = neg_a;
      // divide path carries magnitudes, all other ops the masked operands
      item.left  = (is_divrem && neg_a) ? ((-a) & mask) : a;
      item.right = (is_divrem && neg_b) ? ((-b) & mask) : b;
   end

   wsalu_fifo #(
      .WIDTH (wsalu_pkg::ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .data_in  (item),
      .full     (full),
      .pop      (take),
      .data_out (head_bits),
      .empty    (empty),
      .count    (unused_count)
   );

   assign head = wsalu_pkg::item_type'(head_bits);

endmodule

// ===== rtl/wsalu_div.sv =====
module wsalu_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  wsalu_pkg::item_type          item,
   output logic                         busy,
   output logic                         done,
   output logic [wsalu_pkg::DATA_W-1:0] result
);

   localparam int STEP_W = $clog2(wsalu_pkg::DATA_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(wsalu_pkg::DATA_W-1);

   logic                         busy_ff, busy_in, done_ff, done_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [wsalu_pkg::DATA_W-1:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [2:0]                   act_ff, act_in;
   logic [1:0]                   wc_ff, wc_in;
   logic                         nq_ff, nq_in, nr_ff, nr_in;
   logic [wsalu_pkg::DATA_W:0]   trial;
   logic [wsalu_pkg::DATA_W-1:0] pick;
   logic                         neg;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      act_in  = act_ff;
      wc_in   = wc_ff;
      nq_in   = nq_ff;
      nr_in   = nr_ff;
      trial   = {rem_ff, quo_ff[wsalu_pkg::DATA_W-1]} - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = item.left;
         rem_in  = '0;
         dvs_in  = item.right;
         act_in  = item.action;
         wc_in   = item.width_code;
         nq_in   = item.neg_quo;
         nr_in   = item.neg_rem;
      end else if (done_ff) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         // restoring step: one quotient bit per cycle
         if (!trial[wsalu_pkg::DATA_W]) begin
            rem_in = trial[wsalu_pkg::DATA_W-1:0];
         end else begin
            rem_in = {rem_ff[wsalu_pkg::DATA_W-2:0], quo_ff[wsalu_pkg::DATA_W-1]};
         end
         quo_in  = {quo_ff[wsalu_pkg::DATA_W-2:0], !trial[wsalu_pkg::DATA_W]};
         step_in = step_ff + 1'b1;
         done_in = (step_ff == LAST_STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      act_ff <= act_in;
      wc_ff  <= wc_in;
      nq_ff  <= nq_in;
      nr_ff  <= nr_in;
   end

   always_comb begin
      pick   = (act_ff == wsalu_pkg::OP_DIV) ? quo_ff : rem_ff;
      neg    = (act_ff == wsalu_pkg::OP_DIV) ? nq_ff : nr_ff;
      result = (neg ? -pick : pick) & wsalu_pkg::width_mask(wc_ff);
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule

// ===== rtl/wsalu_back.sv =====
module wsalu_back #(
   parameter int RESULT_DEPTH = wsalu_pkg::RESULT_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  wsalu_pkg::item_type          head,
   input  logic                         head_empty,
   output logic                         take,
   input  logic                         pop,
   output logic                         empty,
   output logic [wsalu_pkg::DATA_W-1:0] result_value
);

   localparam int DW    = wsalu_pkg::DATA_W;
   localparam int HW    = wsalu_pkg::HALF_W;
   localparam int CNT_W = $clog2(RESULT_DEPTH+1);
   localparam int SUM_W = $clog2(RESULT_DEPTH+4);

   logic              va_ff, va_in, vb_ff, vb_in;
   logic              mul_a_ff, mul_a_in;
   logic [1:0]        wc_a_ff, wc_a_in;
   logic [DW-1:0]     p0_ff, p0_in, r_a_ff, r_a_in;
   logic [HW-1:0]     p1_ff, p1_in, p2_ff, p2_in;
   logic [DW-1:0]     r_b_ff, r_b_in;
   logic              is_div, div_start, div_busy, div_done, out_full, out_push;
   logic [DW-1:0]     div_result, out_data;
   logic [CNT_W-1:0]  out_count;
   logic [SUM_W-1:0]  committed;

   always_comb begin
      is_div = ((head.action == wsalu_pkg::OP_DIV) || (head.action == wsalu_pkg::OP_REM))
               && !head.div_zero;
      // space in the result queue is reserved for everything in flight
      committed = SUM_W'(out_count) + SUM_W'(va_ff) + SUM_W'(vb_ff) + SUM_W'(div_busy);
      take      = !head_empty && !div_busy && (committed < SUM_W'(RESULT_DEPTH));
      div_start = take && is_div;
   end

   always_comb begin
      va_in    = take && !is_div;
      mul_a_in = (head.action == wsalu_pkg::OP_MUL);
      wc_a_in  = head.width_code;
      p0_in    = DW'(head.left[HW-1:0] * head.right[HW-1:0]);
      p1_in    = HW'(head.left[HW-1:0] * head.right[DW-1:HW]);
      p2_in    = HW'(head.left[DW-1:HW] * head.right[HW-1:0]);
      case (head.action)
         wsalu_pkg::OP_ADD: r_a_in = head.left + head.right;
         wsalu_pkg::OP_SUB: r_a_in = head.left - head.right;
         wsalu_pkg::OP_AND: r_a_in = head.left & head.right;
         wsalu_pkg::OP_OR:  r_a_in = head.left | head.right;
         wsalu_pkg::OP_XOR: r_a_in = head.left ^ head.right;
         default:           r_a_in = '0;
      endcase
      vb_in  = va_ff;
      r_b_in = (mul_a_ff ? (p0_ff + {p1_ff + p2_ff, {HW{1'b0}}}) : r_a_ff)
               & wsalu_pkg::width_mask(wc_a_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_a_ff <= mul_a_in;
      wc_a_ff  <= wc_a_in;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      r_a_ff   <= r_a_in;
      r_b_ff   <= r_b_in;
   end

   wsalu_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .item   (head),
      .busy   (div_busy),
      .done   (div_done),
      .result (div_result)
   );

   assign out_push = vb_ff || div_done;
   assign out_data = div_done ? div_result : r_b_ff;

   wsalu_fifo #(
      .WIDTH (DW),
      .DEPTH (RESULT_DEPTH)
   ) u_results (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .data_in  (out_data),
      .full     (out_full),
      .pop      (pop),
      .data_out (result_value),
      .empty    (empty),
      .count    (out_count)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result written into a full queue");

   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      !(vb_ff && div_done))
      else $error("pipeline and divider wrote a result in the same cycle");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divide started while the divider was busy");

   a_div_done_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      div_done |-> !va_ff && !take)
      else $error("pipeline active when divide result retired");

endmodule

// ===== rtl/width_select_integer_alu.sv =====
// integer alu with selectable operand width (8, 16, 32 or 64 bits)
// request side is a queue: drive req_* fields with req_push; the beat is taken
// on a rising edge where req_push is high and req_full is low
// response side is a queue: while rsp_empty is low rsp_result_value holds the
// oldest result; raise rsp_pop to take that beat
// results come back in request order, one per request
// add, sub, mul and logic ops pass the request queue, two back stages and the
// response queue, one beat per cycle sustained while no divide is in progress and
// the response queue has room; mul runs as 32x32 partial products over two back
// stages; div and rem use the radix-2 divider that produces one quotient bit per
// cycle; the divider holds one operation at a time and later requests wait behind it
// divide or remainder by zero returns 0 without using the divider
// reset clears both queues and the divider; pending beats are dropped
// when rsp_pop stays low the response queue fills, the back end stops drawing
// from the request queue and req_full rises once that queue is full too
module width_select_integer_alu #(
   parameter int QUEUE_DEPTH  = wsalu_pkg::QUEUE_DEPTH_DEF,
   parameter int RESULT_DEPTH = wsalu_pkg::RESULT_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [2:0]                   req_action,
   input  logic [1:0]                   req_width_code,
   input  logic                         req_signed_op,
   input  logic [wsalu_pkg::DATA_W-1:0] req_left_operand,
   input  logic [wsalu_pkg::DATA_W-1:0] req_right_operand,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [wsalu_pkg::DATA_W-1:0] rsp_result_value
);

   wsalu_pkg::item_type head;
   logic                head_empty, take;

   wsalu_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .full          (req_full),
      .action        (req_action),
      .width_code    (req_width_code),
      .signed_op     (req_signed_op),
      .left_operand  (req_left_operand),
      .right_operand (req_right_operand),
      .take          (take),
      .head          (head),
      .empty         (head_empty)
   );

   wsalu_back #(
      .RESULT_DEPTH (RESULT_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_empty   (head_empty),
      .take         (take),
      .pop          (rsp_pop),
      .empty        (rsp_empty),
      .result_value (rsp_result_value)
   );

endmodule
